// ===== rtl/vertex_screen_projection_defines.svh =====
// Assertion macros used by the checker file
`ifndef VERTEX_SCREEN_PROJECTION_DEFINES_SVH
`define VERTEX_SCREEN_PROJECTION_DEFINES_SVH

// a holds -> c holds in the same cycle
`define VSP_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("vsp same-cycle check failed");

// a holds -> c holds in the next cycle
`define VSP_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("vsp next-cycle check failed");

`endif

// ===== rtl/vsp_pkg.sv =====
package vsp_pkg;
	localparam int VERT_W = 24;
	localparam int COEF_W = 16;
	localparam int PROD_W = VERT_W + COEF_W;
	localparam int CLIP_W = PROD_W + 2;
	localparam int CLIP_HALF = CLIP_W / 2;
	localparam int VP_W = 13;
	localparam int OUT_W = 21;
	localparam int Q_BITS = 23;
	localparam int DEN_W = CLIP_W + 1;
	localparam int NUM_W = 60;
	localparam int MAG_W = 58;
	localparam int SUM_W = 26;
	localparam int XF_LAT = 2;
	localparam int AXIS_LAT = Q_BITS + 4;
	localparam int LAT = XF_LAT + AXIS_LAT;

	localparam logic [2:0] REG_ROW_X = 3'd0;
	localparam logic [2:0] REG_ROW_Y = 3'd1;
	localparam logic [2:0] REG_ROW_W = 3'd2;
	localparam logic [2:0] REG_ORG_X = 3'd3;
	localparam logic [2:0] REG_ORG_Y = 3'd4;
	localparam logic [2:0] REG_WIDTH = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW_W_RST = 64'h1000_0000_0000_0000;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
endpackage

// ===== rtl/vsp_xform.sv =====
module vsp_xform (
	input  logic clk,
	input  logic en,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_x,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_y,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_z,
	input  logic [63:0] row_x,
	input  logic [63:0] row_y,
	input  logic [63:0] row_w,
	output logic signed [vsp_pkg::CLIP_W-1:0] clip_x,
	output logic signed [vsp_pkg::CLIP_W-1:0] clip_y,
	output logic signed [vsp_pkg::CLIP_W-1:0] clip_w
);
	import vsp_pkg::*;

	logic [63:0] rows [3];
	logic signed [PROD_W-1:0] pa_s1 [3];
	logic signed [PROD_W-1:0] pb_s1 [3];
	logic signed [PROD_W-1:0] pc_s1 [3];
	logic signed [CLIP_W-1:0] pt_s1 [3];
	logic signed [CLIP_W-1:0] clip_s2 [3];

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_w;

	for (genvar r = 0; r < 3; r++) begin : g_row
		logic signed [COEF_W-1:0] ca, cb, cc, ct;
		assign ca = rows[r][15:0];
		assign cb = rows[r][31:16];
		assign cc = rows[r][47:32];
		assign ct = rows[r][63:48];

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[r] <= ca * vertex_x;
				pb_s1[r] <= cb * vertex_y;
				pc_s1[r] <= cc * vertex_z;
				pt_s1[r] <= CLIP_W'(ct) <<< 12;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				clip_s2[r] <= CLIP_W'(pa_s1[r]) + CLIP_W'(pb_s1[r]) + CLIP_W'(pc_s1[r])
					+ pt_s1[r];
			end
		end
	end

	assign clip_x = clip_s2[0];
	assign clip_y = clip_s2[1];
	assign clip_w = clip_s2[2];
endmodule

// ===== rtl/vsp_axis.sv =====
module vsp_axis (
	input  logic clk,
	input  logic en,
	input  logic signed [vsp_pkg::CLIP_W-1:0] clip,
	input  logic signed [vsp_pkg::CLIP_W-1:0] clip_w,
	input  logic signed [vsp_pkg::VP_W-1:0] origin,
	input  logic [vsp_pkg::VP_W-1:0] size,
	output logic signed [vsp_pkg::OUT_W-1:0] screen
);
	import vsp_pkg::*;

	logic [VP_W+2:0] sz8;
	logic [CLIP_HALF-1:0] clip_lo;
	logic signed [CLIP_W-CLIP_HALF-1:0] clip_hi;

	logic [VP_W+2+CLIP_HALF:0] plo_s3;
	logic signed [VP_W+3+CLIP_W-CLIP_HALF:0] phi_s3;
	logic signed [CLIP_W-1:0] cw_s3;

	logic signed [MAG_W:0] num;
	logic [MAG_W-1:0] an_s4;
	logic [CLIP_W-1:0] ad_s4;
	logic neg_s4;

	logic [NUM_W-1:0] nsum;
	logic [DEN_W-1:0] rem_s [Q_BITS+1];
	logic [Q_BITS-1:0] nlo_s [Q_BITS+1];
	logic [Q_BITS-1:0] q_s [Q_BITS+1];
	logic [DEN_W-1:0] den_s [Q_BITS+1];
	logic neg_s [Q_BITS+1];
	logic ovf_s [Q_BITS+1];

	logic [Q_BITS-1:0] qmag;
	logic signed [SUM_W-1:0] qs, total;
	logic signed [OUT_W-1:0] screen_s29;

	assign sz8 = {size, 3'b000};
	assign clip_lo = clip[CLIP_HALF-1:0];
	assign clip_hi = clip[CLIP_W-1:CLIP_HALF];

	// 16 x 42 split into two partial products
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3 <= sz8 * clip_lo;
			phi_s3 <= $signed({1'b0, sz8}) * clip_hi;
			cw_s3 <= clip_w;
		end
	end

	assign num = ((MAG_W+1)'(phi_s3) <<< CLIP_HALF) + $signed((MAG_W+1)'(plo_s3));

	always_ff @(posedge clk) begin
		if (en) begin
			an_s4 <= num[MAG_W] ? MAG_W'(-num) : MAG_W'(num);
			ad_s4 <= cw_s3[CLIP_W-1] ? CLIP_W'(-cw_s3) : CLIP_W'(cw_s3);
			neg_s4 <= num[MAG_W] ^ cw_s3[CLIP_W-1];
		end
	end

	// rounding: q = floor((2|num| + |w|) / (2|w|))
	assign nsum = (NUM_W'(an_s4) << 1) + NUM_W'(ad_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(nsum[NUM_W-1:Q_BITS]);
			nlo_s[0] <= nsum[Q_BITS-1:0];
			q_s[0] <= '0;
			den_s[0] <= {ad_s4, 1'b0};
			neg_s[0] <= neg_s4;
			ovf_s[0] <= DEN_W'(nsum[NUM_W-1:Q_BITS]) >= {ad_s4, 1'b0};
		end
	end

	// one restoring quotient bit per stage
	for (genvar k = 0; k < Q_BITS; k++) begin : g_div
		logic [DEN_W:0] r2;
		logic ge;
		assign r2 = {rem_s[k], nlo_s[k][Q_BITS-1]};
		assign ge = r2 >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DEN_W'(r2 - {1'b0, den_s[k]}) : r2[DEN_W-1:0];
				nlo_s[k+1] <= nlo_s[k] << 1;
				q_s[k+1] <= {q_s[k][Q_BITS-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// an overflowed quotient saturates whatever the viewport terms
	assign qmag = ovf_s[Q_BITS] ? '1 : q_s[Q_BITS];
	assign qs = neg_s[Q_BITS] ? -$signed(SUM_W'(qmag)) : $signed(SUM_W'(qmag));
	assign total = (SUM_W'(origin) <<< 4) + $signed(SUM_W'({size, 3'b000})) + qs;

	always_ff @(posedge clk) begin
		if (en) begin
			if (total > SUM_W'(OUT_MAX))
				screen_s29 <= OUT_MAX;
			else if (total < SUM_W'(OUT_MIN))
				screen_s29 <= OUT_MIN;
			else
				screen_s29 <= total[OUT_W-1:0];
		end
	end

	assign screen = screen_s29;
endmodule

// ===== rtl/vertex_screen_projection.sv =====
// Pipeline: 2 transform stages, 3 scale stages, 23 divider stages, 1 viewport/saturate stage.
// Throughput: one vertex per cycle; the divider's one quotient bit per stage sets the depth.
// The whole pipeline holds while a result waits on out_stall.
// Reset (arst_n low, asynchronous) clears the valid bits and loads the identity
// rows and a zero viewport.
module vertex_screen_projection (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_x,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_y,
	input  logic signed [vsp_pkg::VERT_W-1:0] vertex_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [vsp_pkg::OUT_W-1:0] screen_x,
	output logic signed [vsp_pkg::OUT_W-1:0] screen_y,
	output logic w_is_zero,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import vsp_pkg::*;

	logic en;
	logic [63:0] row_x_q, row_y_q, row_w_q;
	logic signed [VP_W-1:0] org_x_q, org_y_q;
	logic [VP_W-1:0] width_q, height_q;
	logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
	logic signed [OUT_W-1:0] sx, sy;
	logic [LAT-1:0] v_s;
	logic [AXIS_LAT-1:0] wz_s;

	assign en = !(v_s[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= ROW_X_RST;
			row_y_q <= ROW_Y_RST;
			row_w_q <= ROW_W_RST;
			org_x_q <= '0;
			org_y_q <= '0;
			width_q <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_X:  row_x_q <= cfg_data;
				REG_ROW_Y:  row_y_q <= cfg_data;
				REG_ROW_W:  row_w_q <= cfg_data;
				REG_ORG_X:  org_x_q <= cfg_data[VP_W-1:0];
				REG_ORG_Y:  org_y_q <= cfg_data[VP_W-1:0];
				REG_WIDTH:  width_q <= cfg_data[VP_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[VP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s <= {wz_s[AXIS_LAT-2:0], clip_w == '0};
		end
	end

	vsp_xform u_xform (
		.clk(clk), .en(en),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.row_x(row_x_q), .row_y(row_y_q), .row_w(row_w_q),
		.clip_x(clip_x), .clip_y(clip_y), .clip_w(clip_w)
	);

	vsp_axis u_axis_x (
		.clk(clk), .en(en), .clip(clip_x), .clip_w(clip_w),
		.origin(org_x_q), .size(width_q), .screen(sx)
	);

	vsp_axis u_axis_y (
		.clk(clk), .en(en), .clip(clip_y), .clip_w(clip_w),
		.origin(org_y_q), .size(height_q), .screen(sy)
	);

	assign out_valid = v_s[LAT-1];
	assign w_is_zero = wz_s[AXIS_LAT-1];
	assign screen_x = wz_s[AXIS_LAT-1] ? '0 : sx;
	assign screen_y = wz_s[AXIS_LAT-1] ? '0 : sy;
endmodule

// ===== rtl/vsp_checker.sv =====
`include "vertex_screen_projection_defines.svh"

module vsp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [vsp_pkg::OUT_W-1:0] screen_x,
	input logic signed [vsp_pkg::OUT_W-1:0] screen_y,
	input logic w_is_zero
);
	// a held result stays offered
	`VSP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	// input only blocked by a waiting result
	`VSP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
	// zero clip w gives zero coordinates
	`VSP_ASSERT_IMP(a_wzero_coords, out_valid && w_is_zero, screen_x == '0 && screen_y == '0)
endmodule

bind vertex_screen_projection vsp_checker u_vsp_checker (.*);
